/* design/oes_pkg.sv */
package oes_pkg;

    localparam int WORD_W   = 48;
    localparam int FRAC_W   = 32;
    localparam int DAY_W    = 51;
    localparam int H_W      = 32;
    localparam int MASS_W   = 10;
    localparam int DUR_W    = 10;
    localparam int TIME_W   = 48;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int SUMSQ_W  = 96;
    localparam int ROOT_W   = 48;
    localparam int QUOT_W   = 63;
    localparam int ITER_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAR_MASS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 2'd2;

    localparam logic [H_W-1:0]    STEP_SIZE_RST = 32'd11767033;
    localparam logic [MASS_W-1:0] STAR_MASS_RST = 10'd1;
    localparam logic [DUR_W-1:0]  DURATION_RST  = 10'd1;

    // 365.242 and 4*pi^2, both Q.32
    localparam logic [40:0] K_DAYS = 41'd1568702445126;
    localparam logic [37:0] G_Q32  = 38'd169558512508;
    localparam logic [QUOT_W-1:0] QCAP = 63'h4000_0000_0000_0000;
    localparam int DAYS_PER_YEAR = 365;

    localparam logic [ITER_W-1:0] ITER_SQRT = 8'd48;
    localparam logic [ITER_W-1:0] ITER_DIVA = 8'd128;
    localparam logic [ITER_W-1:0] ITER_DIVB = 8'd96;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LDV, OP_SQ, OP_POS, OP_C, OP_SQRT, OP_DIVA, OP_DIVB, OP_ACC
    } op_t;

    typedef struct packed {
        logic       start;
        op_t        op;
        logic [1:0] idx;
        logic       load;
        logic       init;
        logic       commit;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic s_zero;
        logic run_over;
        logic last;
    } dp_sts_t;

    function automatic logic [WORD_W-1:0] mag48(word_t a);
        logic [WORD_W-1:0] u;
        u = a;
        return a[WORD_W-1] ? (~u + 48'd1) : u;
    endfunction

    function automatic logic [95:0] rnd32(logic [127:0] p);
        logic [127:0] t;
        t = p + 128'h8000_0000;
        return t[127:32];
    endfunction

    function automatic word_t sat_mag(logic [95:0] m, logic neg);
        word_t v;
        v = word_t'({1'b0, m[WORD_W-2:0]});
        if (|m[95:WORD_W-1]) begin
            return neg ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end
        return neg ? -v : v;
    endfunction

    function automatic word_t sat_add(word_t a, word_t b);
        logic [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1]) begin
            return s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end
        return word_t'(s[WORD_W-1:0]);
    endfunction

endpackage

/* design/oes_mul.sv */
module oes_mul (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod
);
    logic [63:0]  a_reg, b_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg, pv_reg, done_reg;
    logic [31:0]  ah, bh;
    logic [127:0] pp_sh;

    assign ah = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign bh = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb begin
        case (sh_reg)
            2'd0:    pp_sh = {64'd0, pp_reg};
            2'd1:    pp_sh = {32'd0, pp_reg, 32'd0};
            default: pp_sh = {pp_reg, 64'd0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= a;
                b_reg    <= b;
                acc_reg  <= '0;
                cnt_reg  <= 3'd0;
                pv_reg   <= 1'b0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (cnt_reg != 3'd4) begin
                    pp_reg  <= ah * bh;
                    sh_reg  <= 2'({1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]});
                    cnt_reg <= cnt_reg + 3'd1;
                    pv_reg  <= 1'b1;
                end else begin
                    pv_reg <= 1'b0;
                end
                if (pv_reg) begin
                    acc_reg <= acc_reg + pp_sh;
                end
                if (cnt_reg == 3'd4 && pv_reg) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

/* design/oes_iter.sv */
module oes_iter (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic                  sqrt_mode,
    input  logic [63:0]           num,
    input  logic [95:0]           den,
    input  logic [7:0]            iters,
    output logic                  done,
    output logic [62:0]           result
);
    import oes_pkg::*;

    logic [95:0] src_reg, den_reg;
    logic [96:0] rem_reg;
    logic [62:0] q_reg;
    logic [7:0]  cnt_reg;
    logic        mode_reg, busy_reg, done_reg;
    logic [96:0] rs, trial, rem_next;
    logic        ge;
    logic [63:0] q2;
    logic [62:0] q_next;

    always_comb begin
        if (mode_reg) begin
            rs    = {rem_reg[94:0], src_reg[95:94]};
            trial = {32'd0, q_reg, 2'b01};
        end else begin
            rs    = {rem_reg[95:0], src_reg[95]};
            trial = {1'b0, den_reg};
        end
        ge       = (rs >= trial);
        rem_next = ge ? (rs - trial) : rs;
        q2       = {q_reg, ge};
        if (mode_reg) begin
            q_next = {q_reg[61:0], ge};
        end else begin
            q_next = (q2 > {1'b0, QCAP}) ? QCAP : q2[62:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                mode_reg <= sqrt_mode;
                src_reg  <= sqrt_mode ? den : {num, 32'd0};
                den_reg  <= den;
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= iters;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                q_reg   <= q_next;
                src_reg <= mode_reg ? {src_reg[93:0], 2'b00} : {src_reg[94:0], 1'b0};
                cnt_reg <= cnt_reg - 8'd1;
                if (cnt_reg == 8'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = q_reg;

endmodule

/* design/oes_dp.sv */
module oes_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [oes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [oes_pkg::CFG_W-1:0]      cfg_data,
    input  oes_pkg::word_t                 in_pos [3],
    input  oes_pkg::word_t                 in_vel [3],
    input  oes_pkg::dp_cmd_t               cmd,
    output oes_pkg::dp_sts_t               sts,
    output logic [oes_pkg::DAY_W-1:0]      out_day,
    output oes_pkg::word_t                 out_pos [3],
    output oes_pkg::word_t                 out_vel [3],
    output logic                           out_last
);
    import oes_pkg::*;

    logic [H_W-1:0]    step_size_reg;
    logic [MASS_W-1:0] star_mass_reg;
    logic [DUR_W-1:0]  duration_reg;

    word_t pos_reg [3];
    word_t vel_reg [3];
    word_t vin_reg [3];
    word_t np_reg  [3];
    word_t nv_reg  [3];
    word_t opos_reg [3];
    word_t ovel_reg [3];
    logic [TIME_W-1:0]  elapsed_reg;
    logic [SUMSQ_W-1:0] s_reg;
    logic [47:0]        c_reg;
    logic [ROOT_W-1:0]  r_reg;
    logic [QUOT_W-1:0]  a_reg, b_reg;
    logic [DAY_W-1:0]   day_reg;
    logic               last_reg;

    logic [63:0]  ma, mb, it_num;
    logic [95:0]  it_den;
    logic [7:0]   it_cnt;
    logic         mul_start, it_start, mul_done, it_done;
    logic [127:0] prod;
    logic [95:0]  rnd;
    logic [62:0]  it_res;
    logic [47:0]  gm;
    logic [TIME_W:0] next_c;
    logic [41:0]  limit_c;
    logic [56:0]  day_c;
    word_t        p_sel, v_sel, vi_sel;

    assign p_sel  = pos_reg[cmd.idx];
    assign v_sel  = vel_reg[cmd.idx];
    assign vi_sel = vin_reg[cmd.idx];
    assign gm     = 48'(G_Q32 * star_mass_reg);
    assign rnd    = rnd32(prod);

    always_comb begin
        case (cmd.op)
            OP_LDV:  begin ma = {16'd0, mag48(vi_sel)}; mb = {23'd0, K_DAYS}; end
            OP_SQ:   begin ma = {16'd0, mag48(p_sel)};  mb = {16'd0, mag48(p_sel)}; end
            OP_POS:  begin ma = {16'd0, mag48(v_sel)};  mb = {32'd0, step_size_reg}; end
            OP_C:    begin ma = {32'd0, step_size_reg}; mb = {16'd0, gm}; end
            OP_ACC:  begin ma = {1'b0, a_reg};          mb = {1'b0, b_reg}; end
            default: begin ma = '0;                     mb = '0; end
        endcase
    end

    assign mul_start = cmd.start && (cmd.op == OP_LDV || cmd.op == OP_SQ || cmd.op == OP_POS
                                     || cmd.op == OP_C || cmd.op == OP_ACC);
    assign it_start  = cmd.start && (cmd.op == OP_SQRT || cmd.op == OP_DIVA
                                     || cmd.op == OP_DIVB);

    always_comb begin
        case (cmd.op)
            OP_SQRT: begin it_num = '0; it_den = s_reg; it_cnt = ITER_SQRT; end
            OP_DIVA: begin it_num = {16'd0, c_reg}; it_den = s_reg; it_cnt = ITER_DIVA; end
            default: begin
                it_num = {16'd0, mag48(p_sel)};
                it_den = {48'd0, r_reg};
                it_cnt = ITER_DIVB;
            end
        endcase
    end

    oes_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (ma),
        .b       (mb),
        .done    (mul_done),
        .prod    (prod)
    );

    oes_iter u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (it_start),
        .sqrt_mode (cmd.op == OP_SQRT),
        .num       (it_num),
        .den       (it_den),
        .iters     (it_cnt),
        .done      (it_done),
        .result    (it_res)
    );

    assign next_c  = {1'b0, elapsed_reg} + 49'(step_size_reg);
    assign limit_c = {duration_reg, 32'd0};
    assign day_c   = 57'(elapsed_reg) * 57'(DAYS_PER_YEAR);

    assign sts.done     = mul_done || it_done;
    assign sts.s_zero   = (s_reg == '0);
    assign sts.run_over = (elapsed_reg > 48'(limit_c));
    assign sts.last     = (next_c > 49'(limit_c));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg <= STEP_SIZE_RST;
            star_mass_reg <= STAR_MASS_RST;
            duration_reg  <= DURATION_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_STEP_SIZE: step_size_reg <= cfg_data[H_W-1:0];
                REG_STAR_MASS: star_mass_reg <= cfg_data[MASS_W-1:0];
                REG_DURATION:  duration_reg  <= cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg <= '0;
        end else begin
            if (cmd.load) begin
                for (int i = 0; i < 3; i++) begin
                    pos_reg[i] <= in_pos[i];
                    vin_reg[i] <= in_vel[i];
                end
                elapsed_reg <= '0;
            end
            if (cmd.init) begin
                s_reg <= '0;
                for (int i = 0; i < 3; i++) begin
                    nv_reg[i] <= vel_reg[i];
                end
            end
            if (mul_done) begin
                case (cmd.op)
                    OP_LDV: vel_reg[cmd.idx] <= sat_mag(rnd, vi_sel[WORD_W-1]);
                    OP_SQ:  s_reg <= s_reg + prod[SUMSQ_W-1:0];
                    OP_POS: np_reg[cmd.idx] <= sat_add(p_sel, sat_mag(rnd, v_sel[WORD_W-1]));
                    OP_C:   c_reg <= rnd[47:0];
                    OP_ACC: nv_reg[cmd.idx] <= sat_add(v_sel,
                                sat_mag(rnd, !p_sel[WORD_W-1] && (|p_sel)));
                    default: ;
                endcase
            end
            if (it_done) begin
                case (cmd.op)
                    OP_SQRT: r_reg <= it_res[ROOT_W-1:0];
                    OP_DIVA: a_reg <= it_res;
                    OP_DIVB: b_reg <= it_res;
                    default: ;
                endcase
            end
            if (cmd.commit) begin
                for (int i = 0; i < 3; i++) begin
                    pos_reg[i]  <= np_reg[i];
                    vel_reg[i]  <= nv_reg[i];
                    opos_reg[i] <= np_reg[i];
                    ovel_reg[i] <= nv_reg[i];
                end
                elapsed_reg <= next_c[TIME_W-1:0];
                day_reg     <= day_c[DAY_W-1:0];
                last_reg    <= sts.last;
            end
        end
    end

    assign out_day  = day_reg;
    assign out_pos  = opos_reg;
    assign out_vel  = ovel_reg;
    assign out_last = last_reg;

endmodule

/* design/oes_ctrl.sv */
module oes_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    output logic              m_valid,
    input  logic              m_ready,
    input  oes_pkg::dp_sts_t  sts,
    output oes_pkg::dp_cmd_t  cmd
);
    import oes_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LDV, S_SQ, S_POS, S_C, S_SQRT, S_DIVA, S_DIVB, S_ACC, S_COMMIT
    } state_t;

    state_t     state_reg;
    op_t        op_reg;
    logic [1:0] idx_reg;
    logic       start_reg, running_reg, m_valid_reg;
    logic       accept, idx_last, slot_free;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign idx_last  = (idx_reg == 2'd2);
    assign slot_free = !m_valid_reg || m_ready;

    assign cmd.start  = start_reg;
    assign cmd.op     = op_reg;
    assign cmd.idx    = idx_reg;
    assign cmd.load   = accept && !s_cmd;
    assign cmd.init   = accept && s_cmd && running_reg && !sts.run_over;
    assign cmd.commit = (state_reg == S_COMMIT) && slot_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_NONE;
            idx_reg     <= 2'd0;
            start_reg   <= 1'b0;
            running_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (!s_cmd) begin
                            state_reg <= S_LDV; op_reg <= OP_LDV;
                            idx_reg <= 2'd0; start_reg <= 1'b1;
                        end else if (running_reg && !sts.run_over) begin
                            state_reg <= S_SQ; op_reg <= OP_SQ;
                            idx_reg <= 2'd0; start_reg <= 1'b1;
                        end else begin
                            running_reg <= 1'b0;
                        end
                    end
                end
                S_LDV: begin
                    if (sts.done) begin
                        if (!idx_last) begin
                            idx_reg <= idx_reg + 2'd1; start_reg <= 1'b1;
                        end else begin
                            state_reg <= S_IDLE; op_reg <= OP_NONE;
                            running_reg <= 1'b1;
                        end
                    end
                end
                S_SQ: begin
                    if (sts.done) begin
                        if (!idx_last) begin
                            idx_reg <= idx_reg + 2'd1;
                        end else begin
                            state_reg <= S_POS; op_reg <= OP_POS; idx_reg <= 2'd0;
                        end
                        start_reg <= 1'b1;
                    end
                end
                S_POS: begin
                    if (sts.done) begin
                        if (!idx_last) begin
                            idx_reg <= idx_reg + 2'd1; start_reg <= 1'b1;
                        end else if (sts.s_zero) begin
                            state_reg <= S_COMMIT; op_reg <= OP_NONE;
                        end else begin
                            state_reg <= S_C; op_reg <= OP_C; start_reg <= 1'b1;
                        end
                    end
                end
                S_C: begin
                    if (sts.done) begin
                        state_reg <= S_SQRT; op_reg <= OP_SQRT; start_reg <= 1'b1;
                    end
                end
                S_SQRT: begin
                    if (sts.done) begin
                        state_reg <= S_DIVA; op_reg <= OP_DIVA; start_reg <= 1'b1;
                    end
                end
                S_DIVA: begin
                    if (sts.done) begin
                        state_reg <= S_DIVB; op_reg <= OP_DIVB;
                        idx_reg <= 2'd0; start_reg <= 1'b1;
                    end
                end
                S_DIVB: begin
                    if (sts.done) begin
                        state_reg <= S_ACC; op_reg <= OP_ACC; start_reg <= 1'b1;
                    end
                end
                S_ACC: begin
                    if (sts.done) begin
                        if (!idx_last) begin
                            state_reg <= S_DIVB; op_reg <= OP_DIVB;
                            idx_reg <= idx_reg + 2'd1; start_reg <= 1'b1;
                        end else begin
                            state_reg <= S_COMMIT; op_reg <= OP_NONE;
                        end
                    end
                end
                S_COMMIT: begin
                    if (slot_free) begin
                        if (sts.last) begin
                            running_reg <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;

    a_commit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("commit into an occupied output register");

    a_commit_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("commit did not raise m_valid");

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.done |-> (state_reg != S_IDLE && state_reg != S_COMMIT))
        else $error("unit finished with no operation in flight");

    a_start_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |=> !start_reg)
        else $error("operation start held for more than one cycle");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> !s_ready)
        else $error("input ready while an operation starts");

endmodule

/* design/orbit_euler_step.sv */
// Forward-Euler two-body integrator, Q16.32 fixed point throughout. A load beat
// (s_cmd = 0) sets position and velocity (AU/day, scaled to AU/year) and restarts
// time; it gives no result. A step beat (s_cmd = 1) gives one result beat with
// the step's start day and the new state, using ten 64x64 products on an
// iterative 32x32 multiplier, a square root and four radix-2 divisions on one
// shared iterative unit. With the body at the origin the step skips the C and
// ACC products, the square root and the divisions. Steps while idle or past
// the run end are absorbed with no result. One beat is in flight at a time; a
// finished result waits in the output register while the next beat is taken.
module orbit_euler_step (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [oes_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [oes_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_cmd,
    input  logic signed [oes_pkg::WORD_W-1:0]    s_pos_x,
    input  logic signed [oes_pkg::WORD_W-1:0]    s_pos_y,
    input  logic signed [oes_pkg::WORD_W-1:0]    s_pos_z,
    input  logic signed [oes_pkg::WORD_W-1:0]    s_vel_x,
    input  logic signed [oes_pkg::WORD_W-1:0]    s_vel_y,
    input  logic signed [oes_pkg::WORD_W-1:0]    s_vel_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [oes_pkg::DAY_W-1:0]            m_day,
    output logic signed [oes_pkg::WORD_W-1:0]    m_new_x,
    output logic signed [oes_pkg::WORD_W-1:0]    m_new_y,
    output logic signed [oes_pkg::WORD_W-1:0]    m_new_z,
    output logic signed [oes_pkg::WORD_W-1:0]    m_new_vx,
    output logic signed [oes_pkg::WORD_W-1:0]    m_new_vy,
    output logic signed [oes_pkg::WORD_W-1:0]    m_new_vz,
    output logic                                 m_last
);
    import oes_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    word_t   in_pos [3];
    word_t   in_vel [3];
    word_t   out_pos [3];
    word_t   out_vel [3];

    assign in_pos[0] = s_pos_x;
    assign in_pos[1] = s_pos_y;
    assign in_pos[2] = s_pos_z;
    assign in_vel[0] = s_vel_x;
    assign in_vel[1] = s_vel_y;
    assign in_vel[2] = s_vel_z;

    oes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    oes_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_pos    (in_pos),
        .in_vel    (in_vel),
        .cmd       (cmd),
        .sts       (sts),
        .out_day   (m_day),
        .out_pos   (out_pos),
        .out_vel   (out_vel),
        .out_last  (m_last)
    );

    assign m_new_x  = out_pos[0];
    assign m_new_y  = out_pos[1];
    assign m_new_z  = out_pos[2];
    assign m_new_vx = out_vel[0];
    assign m_new_vy = out_vel[1];
    assign m_new_vz = out_vel[2];

endmodule

/* tb/orbit_euler_step_tb.sv */
module orbit_euler_step_tb;
    import oes_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam bit CMD_LOAD = 1'b0;
    localparam bit CMD_STEP = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam longint WMAX = (64'sd1 <<< 47) - 1;
    localparam longint WMIN = -WMAX - 1;
    localparam int SETTLE_CYCLES = 700;
    localparam int WD_LIMIT = 20000;

    typedef struct {
        logic [DAY_W-1:0] day;
        word_t x, y, z, vx, vy, vz;
        logic last;
    } orbit_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_cmd = 1'b0;
    word_t s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    word_t s_vel_x = '0, s_vel_y = '0, s_vel_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [DAY_W-1:0] m_day;
    word_t m_new_x, m_new_y, m_new_z, m_new_vx, m_new_vy, m_new_vz;
    logic m_last;

    orbit_euler_step u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_vel_x(s_vel_x), .s_vel_y(s_vel_y), .s_vel_z(s_vel_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_day(m_day),
        .m_new_x(m_new_x), .m_new_y(m_new_y), .m_new_z(m_new_z),
        .m_new_vx(m_new_vx), .m_new_vy(m_new_vy), .m_new_vz(m_new_vz),
        .m_last(m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // orbit state as the block should hold it
    logic [H_W-1:0]    h_years;
    logic [MASS_W-1:0] mass_sol;
    logic [DUR_W-1:0]  dur_years;
    longint            body_pos[3], body_vel[3];
    logic [63:0]       elapsed;
    bit                running;

    orbit_res_t expected_steps[$];
    int src_idle_pct = 0, snk_idle_pct = 0;
    int mismatches = 0;
    int wd_count = 0;

    function automatic logic [63:0] mag64(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic logic [127:0] round32(logic [127:0] p);
        return (p + 128'h8000_0000) >> 32;
    endfunction

    function automatic longint clamp_mag(logic [127:0] m, bit neg);
        if (m > 128'(WMAX)) return neg ? WMIN : WMAX;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint scale_q32(longint a, logic [63:0] b);
        return clamp_mag(round32(128'(mag64(a)) * 128'(b)), a < 0);
    endfunction

    function automatic longint add_clamp(longint a, longint b);
        longint s;
        s = a + b;
        if (s > WMAX) return WMAX;
        if (s < WMIN) return WMIN;
        return s;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [127:0] s);
        logic [63:0] res, cand;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if (s >= 128'(cand) * 128'(cand)) res = cand;
        end
        return res;
    endfunction

    task automatic reset_orbit_state();
        h_years = STEP_SIZE_RST;
        mass_sol = STAR_MASS_RST;
        dur_years = DURATION_RST;
        for (int i = 0; i < 3; i++) begin
            body_pos[i] = 0;
            body_vel[i] = 0;
        end
        elapsed = '0;
        running = 0;
    endtask

    task automatic advance_orbit(bit cmd, word_t p[3], word_t v[3]);
        logic [63:0] limit, nxt, root, c, acc, b;
        logic [127:0] s, q;
        longint np[3], nv[3];
        orbit_res_t r;
        if (cmd == CMD_LOAD) begin
            for (int i = 0; i < 3; i++) begin
                body_pos[i] = longint'(p[i]);
                body_vel[i] = scale_q32(longint'(v[i]), 64'(K_DAYS));
            end
            elapsed = '0;
            running = 1;
            return;
        end
        if (!running) return;
        limit = 64'(dur_years) << 32;
        if (elapsed > limit) begin
            running = 0;
            return;
        end
        nxt = elapsed + 64'(h_years);
        s = '0;
        for (int i = 0; i < 3; i++) begin
            s += 128'(mag64(body_pos[i])) * 128'(mag64(body_pos[i]));
            np[i] = add_clamp(body_pos[i], scale_q32(body_vel[i], 64'(h_years)));
            nv[i] = body_vel[i];
        end
        if (s != 0) begin
            root = floor_sqrt(s);
            c = 64'(round32(128'(h_years) * (128'(G_Q32) * 128'(mass_sol))));
            q = (128'(c) << 64) / s;
            acc = (q > 128'(QCAP)) ? 64'(QCAP) : q[63:0];
            for (int i = 0; i < 3; i++) begin
                b = 64'((128'(mag64(body_pos[i])) << 32) / 128'(root));
                nv[i] = add_clamp(body_vel[i],
                    clamp_mag(round32(128'(acc) * 128'(b)), body_pos[i] > 0));
            end
        end
        r.day = DAY_W'(elapsed * 64'd365);
        r.x = word_t'(np[0]);  r.y = word_t'(np[1]);  r.z = word_t'(np[2]);
        r.vx = word_t'(nv[0]); r.vy = word_t'(nv[1]); r.vz = word_t'(nv[2]);
        r.last = nxt > limit;
        expected_steps.push_back(r);
        for (int i = 0; i < 3; i++) begin
            body_pos[i] = np[i];
            body_vel[i] = nv[i];
        end
        elapsed = nxt & 64'hFFFF_FFFF_FFFF;
        if (r.last) running = 0;
    endtask

    // one beat on the input channel; returns at the accepting edge
    task automatic send_beat(bit cmd, word_t p[3], word_t v[3]);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            while ($urandom_range(99) < src_idle_pct) @(posedge aclk);
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_pos_x <= p[0]; s_pos_y <= p[1]; s_pos_z <= p[2];
        s_vel_x <= v[0]; s_vel_y <= v[1]; s_vel_z <= v[2];
        do @(posedge aclk); while (!s_ready);
        advance_orbit(cmd, p, v);
    endtask

    task automatic send_step();
        word_t p[3], v[3];
        for (int i = 0; i < 3; i++) begin
            p[i] = word_t'({$urandom, $urandom});
            v[i] = word_t'({$urandom, $urandom});
        end
        send_beat(CMD_STEP, p, v);
    endtask

    task automatic send_load(longint px, longint py, longint pz,
                             longint vx, longint vy, longint vz);
        word_t p[3], v[3];
        p[0] = word_t'(px); p[1] = word_t'(py); p[2] = word_t'(pz);
        v[0] = word_t'(vx); v[1] = word_t'(vy); v[2] = word_t'(vz);
        send_beat(CMD_LOAD, p, v);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (expected_steps.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_STEP_SIZE: h_years = d;
            REG_STAR_MASS: mass_sol = d[MASS_W-1:0];
            REG_DURATION:  dur_years = d[DUR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] h, logic [9:0] m, logic [9:0] t);
        settle();
        write_reg(REG_STEP_SIZE, h);
        write_reg(REG_STAR_MASS, 32'(m));
        write_reg(REG_DURATION, 32'(t));
    endtask

    function automatic longint rand_word();
        case ($urandom_range(5))
            0: return WMAX;
            1: return WMIN;
            2: return 0;
            default: return longint'(word_t'({$urandom, $urandom}));
        endcase
    endfunction

    function automatic longint orbit_pos();
        return ((longint'($urandom) << 3) | longint'($urandom_range(7)))
               - (64'sd1 <<< 34);
    endfunction

    function automatic longint orbit_vel();
        return longint'($urandom_range(200000000)) - 100000000;
    endfunction

    task automatic test_idle_and_registers();
        send_step();
        send_step();
        configure(32'd11767033, 10'd1, 10'd1);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    endtask

    task automatic test_circular_orbit();
        send_load(64'sd1 <<< 32, 0, 0, 0, 73880000, 0);
        repeat (5) send_step();
        send_load(0, -(64'sd3 <<< 31), 1 <<< 20, -50000000, 0, 12345);
        repeat (3) send_step();
    endtask

    task automatic test_origin_and_extremes();
        send_load(0, 0, 0, 1000000, -1000000, 0);
        send_step();
        send_load(WMAX, WMIN, WMAX, WMAX, WMIN, -1);
        send_step();
        send_load(1, -1, 0, WMIN, WMAX, 1);
        send_step();
        send_step();
    endtask

    task automatic test_run_end();
        configure(32'hFFFF_FFFF, 10'd1023, 10'd1);
        send_load(64'sd1 <<< 32, 0, 0, 0, 73880000, 0);
        repeat (3) send_step();
        // run over at just under two years elapsed, duration cut back below it
        configure(32'hFFFF_FFFF, 10'd1023, 10'd3);
        send_load(64'sd1 <<< 32, 0, 0, 0, 73880000, 0);
        repeat (2) send_step();
        configure(32'hFFFF_FFFF, 10'd1023, 10'd0);
        send_step();
        send_step();
    endtask

    task automatic test_zero_cases();
        configure(32'd0, 10'd0, 10'd0);
        send_load(64'sd2 <<< 32, 64'sd1 <<< 32, 0, 100, 200, 300);
        repeat (2) send_step();
        configure(32'd1, 10'd1, 10'd1023);
        send_load(64'sd1 <<< 32, 0, 0, 0, 73880000, 0);
        send_step();
    endtask

    task automatic test_random_orbits(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) < 7) begin
                int k;
                k = $urandom_range(1, 12);
                send_load(orbit_pos(), orbit_pos(), orbit_pos(),
                          orbit_vel(), orbit_vel(), orbit_vel());
                repeat (k) send_step();
                sent += k + 1;
            end else if ($urandom_range(1)) begin
                send_load(rand_word(), rand_word(), rand_word(),
                          rand_word(), rand_word(), rand_word());
                send_step();
                sent += 2;
            end else begin
                send_step();
                sent += 1;
            end
        end
    endtask

    task automatic test_random_phases();
        int idle_src[3] = '{25, 65, 0};
        int idle_snk[3] = '{65, 25, 0};
        for (int m = 0; m < 3; m++) begin
            src_idle_pct = idle_src[m];
            snk_idle_pct = idle_snk[m];
            configure($urandom, 10'($urandom_range(1, 1023)), 10'($urandom_range(0, 3)));
            test_random_orbits(50);
            configure(32'($urandom_range(1, 50000000)), 10'd1, 10'd1023);
            test_random_orbits(50);
            configure(32'($urandom_range(400000000, 1500000000)), 10'($urandom),
                      10'($urandom_range(1, 2)));
            test_random_orbits(50);
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        orbit_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_steps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
            end else begin
                e = expected_steps.pop_front();
                if (e.day !== m_day || e.x !== m_new_x || e.y !== m_new_y ||
                    e.z !== m_new_z || e.vx !== m_new_vx || e.vy !== m_new_vy ||
                    e.vz !== m_new_vz || e.last !== m_last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t: exp day %h pos %h %h %h vel %h %h %h last %b",
                                 $realtime, e.day, e.x, e.y, e.z, e.vx, e.vy, e.vz, e.last);
                        $display("                 got day %h pos %h %h %h vel %h %h %h last %b",
                                 m_day, m_new_x, m_new_y, m_new_z,
                                 m_new_vx, m_new_vy, m_new_vz, m_last);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            wd_count <= 0;
        end else begin
            wd_count <= wd_count + 1;
        end
        if (wd_count >= WD_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        reset_orbit_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_and_registers();
        test_circular_orbit();
        test_origin_and_extremes();
        test_run_end();
        test_zero_cases();
        test_random_phases();
        settle();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
design/oes_pkg.sv
design/oes_mul.sv
design/oes_iter.sv
design/oes_dp.sv
design/oes_ctrl.sv
design/orbit_euler_step.sv
tb/orbit_euler_step_tb.sv
